@@ hw/rtl/albtp_pkg.sv @@
`default_nettype none

package albtp_pkg;

    // Character codes used by the header parser
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_Q     = 8'h71;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CASE_BIT = 8'h20;

    // Quality of 1.0 in thousandths
    localparam logic [9:0] Q_FULL = 10'd1000;

    // One header byte transaction
    typedef struct packed {
        logic [7:0] hdr_byte;
        logic       end_of_header;
    } in_item_t;

    // One result transaction
    typedef struct packed {
        logic       status;
        logic [7:0] tag_byte;
        logic       byte_valid;
        logic       last;
    } out_item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic take;
        logic close;
        logic load;
        logic clear;
    } ctl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic emit_last;
    } dp_status_t;

    // Fold case and map dash to underscore
    function automatic logic [7:0] norm_byte(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= CH_UP_A && b <= CH_UP_Z) begin
            r = b | CASE_BIT;
        end
        if (b == CH_DASH) begin
            r = CH_UNDER;
        end
        return r;
    endfunction

    // Whitespace and star never reach the parser
    function automatic logic is_dropped(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR) || (b == CH_STAR);
    endfunction

    // Place weight of the n-th fraction digit
    function automatic logic [6:0] frac_weight(input logic [1:0] n);
        logic [6:0] w;
        case (n)
            2'd0:    w = 7'd100;
            2'd1:    w = 7'd10;
            default: w = 7'd1;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/albtp_ctrl.sv @@
`default_nettype none

module albtp_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   hdr_valid,
    input  logic                   hdr_end,
    output logic                   hdr_stall,
    output logic                   res_valid,
    input  logic                   res_stall,
    output albtp_pkg::ctl_cmd_t    cmd,
    input  albtp_pkg::dp_status_t  sts
);
    import albtp_pkg::*;

    typedef enum logic [1:0] {
        S_IN,
        S_CLOSE,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   res_valid_reg, res_valid_next;
    logic   slot_free;

    // Sequence header intake, final close and result burst
    always_comb
    begin
        slot_free      = !res_valid_reg || !res_stall;
        state_next     = state_reg;
        res_valid_next = res_valid_reg && res_stall;
        cmd            = '0;
        case (state_reg)
            S_IN:
            begin
                cmd.take = hdr_valid;
                if (hdr_valid && hdr_end) begin
                    state_next = S_CLOSE;
                end
            end
            S_CLOSE:
            begin
                cmd.close  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free) begin
                    cmd.load       = 1'b1;
                    res_valid_next = 1'b1;
                    if (sts.emit_last) begin
                        cmd.clear  = 1'b1;
                        state_next = S_IN;
                    end
                end
            end
            default:
            begin
                state_next = S_IN;
            end
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IN;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign hdr_stall = (state_reg != S_IN);
    assign res_valid = res_valid_reg;

    a_close_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.close |=> (state_reg == S_EMIT))
        else $error("close not followed by emit");

    a_last_reopens: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && sts.emit_last) |=> (!hdr_stall && res_valid))
        else $error("burst end did not reopen intake");

    a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!res_valid || !res_stall))
        else $error("result loaded over a stalled transaction");

endmodule

`default_nettype wire

@@ hw/rtl/albtp_datapath.sv @@
`default_nettype none

module albtp_datapath #(
    parameter int MAX_TAGS  = 16,
    parameter int TAG_LIMIT = 18
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             hdr_byte,
    input  albtp_pkg::ctl_cmd_t    cmd,
    output albtp_pkg::dp_status_t  sts,
    output albtp_pkg::out_item_t   res_data
);
    import albtp_pkg::*;

    localparam int DEPTH = TAG_LIMIT - 1;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LEN_W = $clog2(TAG_LIMIT + 1);
    localparam int CNT_W = $clog2(MAX_TAGS + 1);

    typedef enum logic [2:0] {
        PH_TEXT,
        PH_SEMI,
        PH_Q,
        PH_EQ,
        PH_INT,
        PH_DOT,
        PH_FRAC,
        PH_SKIP
    } phase_t;

    // Two tag banks: one holds the best tag, the other takes the open tag
    logic [7:0]       store0_reg [DEPTH];
    logic [7:0]       store1_reg [DEPTH];
    logic             bank_reg, bank_next;

    logic [LEN_W-1:0] tok_len_reg, tok_len_next;
    phase_t           phase_reg, phase_next;
    logic [9:0]       q_reg, q_next;
    logic [1:0]       fd_reg, fd_next;
    logic [LEN_W-1:0] best_len_reg, best_len_next;
    logic [9:0]       best_q_reg, best_q_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    out_item_t        res_reg;

    logic [7:0]       b;
    logic             digit;
    logic [3:0]       dval;
    logic [10:0]      frac_sum;
    logic             do_close;
    logic             nonempty;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [7:0]       rd_byte;
    logic             fail;
    out_item_t        item;

    // Parse one normalized byte and close tags
    always_comb
    begin
        b             = norm_byte(hdr_byte);
        digit         = (b >= CH_ZERO) && (b <= CH_NINE);
        dval          = digit ? 4'(b - CH_ZERO) : 4'd0;
        frac_sum      = {1'b0, q_reg} + (11'(dval) * 11'(frac_weight(fd_reg)));
        tok_len_next  = tok_len_reg;
        phase_next    = phase_reg;
        q_next        = q_reg;
        fd_next       = fd_reg;
        best_len_next = best_len_reg;
        best_q_next   = best_q_reg;
        cnt_next      = cnt_reg;
        bank_next     = bank_reg;
        wr_en         = 1'b0;
        wr_idx        = tok_len_reg[IDX_W-1:0];
        do_close      = cmd.close;
        nonempty      = (tok_len_reg != '0) || (phase_reg != PH_TEXT);

        if (cmd.take && !is_dropped(b)) begin
            if (b == CH_COMMA) begin
                do_close = 1'b1;
            end else begin
                case (phase_reg)
                    PH_TEXT:
                    begin
                        if (b == CH_SEMI) begin
                            phase_next = PH_SEMI;
                        end else begin
                            wr_en = (tok_len_reg < LEN_W'(DEPTH));
                            if (tok_len_reg < LEN_W'(TAG_LIMIT)) begin
                                tok_len_next = tok_len_reg + LEN_W'(1);
                            end
                        end
                    end
                    PH_SEMI:
                    begin
                        phase_next = (b == CH_Q) ? PH_Q : PH_SKIP;
                    end
                    PH_Q:
                    begin
                        phase_next = (b == CH_EQ) ? PH_EQ : PH_SKIP;
                    end
                    PH_EQ:
                    begin
                        if (digit) begin
                            q_next     = (dval != 4'd0) ? Q_FULL : 10'd0;
                            fd_next    = 2'd0;
                            phase_next = PH_INT;
                        end else if (b == CH_DOT) begin
                            fd_next    = 2'd0;
                            phase_next = PH_DOT;
                        end else if (b == CH_PLUS && fd_reg == 2'd0) begin
                            fd_next = 2'd1;
                        end else begin
                            fd_next    = 2'd0;
                            phase_next = PH_SKIP;
                        end
                    end
                    PH_INT:
                    begin
                        if (digit) begin
                            if (dval != 4'd0) begin
                                q_next = Q_FULL;
                            end
                        end else if (b == CH_DOT) begin
                            phase_next = PH_FRAC;
                        end else begin
                            phase_next = PH_SKIP;
                        end
                    end
                    PH_DOT:
                    begin
                        if (digit) begin
                            // First fraction digit starts from zero
                            q_next     = 10'(dval) * 10'(frac_weight(2'd0));
                            fd_next    = 2'd1;
                            phase_next = PH_FRAC;
                        end else begin
                            phase_next = PH_SKIP;
                        end
                    end
                    PH_FRAC:
                    begin
                        if (digit) begin
                            if (fd_reg < 2'd3) begin
                                q_next  = (frac_sum > {1'b0, Q_FULL}) ? Q_FULL
                                                                       : frac_sum[9:0];
                                fd_next = fd_reg + 2'd1;
                            end
                        end else begin
                            phase_next = PH_SKIP;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_SKIP;
                    end
                endcase
            end
        end

        // Close the open tag: compete, then reset the tag state
        if (do_close) begin
            if (nonempty && tok_len_reg < LEN_W'(TAG_LIMIT)
                && cnt_reg < CNT_W'(MAX_TAGS)) begin
                if (cnt_reg == '0 || q_reg > best_q_reg) begin
                    bank_next     = !bank_reg;
                    best_len_next = tok_len_reg;
                    best_q_next   = q_reg;
                end
                cnt_next = cnt_reg + CNT_W'(1);
            end
            tok_len_next = '0;
            phase_next   = PH_TEXT;
            q_next       = Q_FULL;
            fd_next      = 2'd0;
        end

        // Drop the parse state, best tag and tag count for the next header
        if (cmd.clear) begin
            tok_len_next  = '0;
            phase_next    = PH_TEXT;
            q_next        = Q_FULL;
            fd_next       = 2'd0;
            best_len_next = '0;
            best_q_next   = 10'd0;
            cnt_next      = '0;
        end
    end

    // Build the next result transaction
    always_comb
    begin
        rd_byte         = bank_reg ? store1_reg[idx_reg] : store0_reg[idx_reg];
        fail            = (cnt_reg == '0) || (best_len_reg == '0);
        item.status     = (cnt_reg == '0);
        item.tag_byte   = fail ? 8'd0 : rd_byte;
        item.byte_valid = !fail;
        item.last       = fail || ((LEN_W'(idx_reg) + LEN_W'(1)) == best_len_reg);
        sts.emit_last   = item.last;
        idx_next        = idx_reg;
        if (cmd.clear) begin
            idx_next = '0;
        end else if (cmd.load) begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            tok_len_reg  <= '0;
            phase_reg    <= PH_TEXT;
            q_reg        <= Q_FULL;
            fd_reg       <= 2'd0;
            best_len_reg <= '0;
            best_q_reg   <= 10'd0;
            cnt_reg      <= '0;
            bank_reg     <= 1'b0;
            idx_reg      <= '0;
        end else begin
            tok_len_reg  <= tok_len_next;
            phase_reg    <= phase_next;
            q_reg        <= q_next;
            fd_reg       <= fd_next;
            best_len_reg <= best_len_next;
            best_q_reg   <= best_q_next;
            cnt_reg      <= cnt_next;
            bank_reg     <= bank_next;
            idx_reg      <= idx_next;
        end
    end

    // Write tag bytes into the bank not holding the best tag; load results
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            if (bank_reg) begin
                store0_reg[wr_idx] <= b;
            end else begin
                store1_reg[wr_idx] <= b;
            end
        end
        if (cmd.load) begin
            res_reg <= item;
        end
    end

    assign res_data = res_reg;

    a_best_len_ok: assert property (@(posedge clk) disable iff (!rst_n)
        best_len_reg < LEN_W'(TAG_LIMIT))
        else $error("best tag longer than the store");

    a_count_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_TAGS))
        else $error("accepted tag count overflow");

    a_idx_in_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && !fail) |-> (LEN_W'(idx_reg) < best_len_reg))
        else $error("emit index past the best tag");

endmodule

`default_nettype wire

@@ hw/rtl/accept_language_best_tag_picker.sv @@
`default_nettype none

// Accept-Language best tag picker. Header bytes come in on the hdr channel one
// transaction per cycle while hdr_stall is low; letters are folded to lower
// case, blanks and '*' are dropped and '-' becomes '_'. Commas split tags,
// ';q=' gives the quality in thousandths, and the first MAX_TAGS tags shorter
// than TAG_LIMIT bytes compete (highest quality wins, earliest on a tie). The
// byte flagged end_of_header is followed by a close of the last tag and then
// a burst of one result per chosen tag byte (or a single failure or empty-tag
// result), one per cycle while res_stall is low. From the close until the
// burst ends hdr_stall is high. Two register banks of TAG_LIMIT-1 bytes swap
// roles when a better tag closes, so tag bytes are never copied.
module accept_language_best_tag_picker #(
    parameter int MAX_TAGS  = 16,
    parameter int TAG_LIMIT = 18
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  hdr_valid,
    output logic                  hdr_stall,
    input  albtp_pkg::in_item_t   hdr_data,
    output logic                  res_valid,
    input  logic                  res_stall,
    output albtp_pkg::out_item_t  res_data
);
    import albtp_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t sts;

    albtp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .hdr_valid (hdr_valid),
        .hdr_end   (hdr_data.end_of_header),
        .hdr_stall (hdr_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    albtp_datapath #(
        .MAX_TAGS  (MAX_TAGS),
        .TAG_LIMIT (TAG_LIMIT)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .hdr_byte (hdr_data.hdr_byte),
        .cmd      (cmd),
        .sts      (sts),
        .res_data (res_data)
    );

endmodule

`default_nettype wire
